/* src/laplacian_noise_estimator_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Laplacian noise estimator.
// Each macro builds one labeled concurrent assertion, or nothing when
// assertions are compiled out.
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_NOISE_ESTIMATOR_TOP_MACROS_SVH
`define LAPLACIAN_NOISE_ESTIMATOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define LNE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lne assertion failed");

// Next-cycle implication.
`define LNE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lne assertion failed");

`else

`define LNE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LNE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* src/lne_pkg.sv */
// ----------------------------------------------------------------------------
// lne_pkg
// Types, constants and codes shared by the noise estimator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lne_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int SUM_W      = 32;
  localparam int SIG_W      = 14;
  localparam int ACC_W      = 33;
  localparam int COEF_W     = 14;
  localparam int PROD_W     = ACC_W + COEF_W;
  localparam int QUO_W      = SIG_W + 1;
  localparam int SIG_STEPS  = QUO_W;
  localparam int FRAC_BITS  = 8;
  localparam int ROUND_SHIFT = FRAC_BITS - 1;
  localparam int DIV_SHIFT  = FRAC_BITS + QUO_W - 1;
  localparam int MIN_SIZE   = 3;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [CFG_W-1:0]  RESET_WIDTH  = CFG_W'(640);
  localparam logic [CFG_W-1:0]  RESET_HEIGHT = CFG_W'(480);
  localparam logic [COEF_W-1:0] SIGMA_COEF   = COEF_W'(13689);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_LOAD
  } lne_state_t;

  typedef struct packed {
    logic take;
    logic calc;
    logic finish;
    logic mul;
    logic prep;
    logic div_step;
    logic load;
  } lne_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic out_full;
  } lne_status_t;

endpackage

`default_nettype wire

/* src/lne_if.sv */
// ----------------------------------------------------------------------------
// lne_pixel_if / lne_result_if
// Valid/ready channels for the pixel stream and the per-frame result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lne_pixel_if
  import lne_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface lne_result_if
  import lne_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] abs_sum;
  logic [SIG_W-1:0] sigma_q8;

  modport source (output valid, output abs_sum, output sigma_q8, input ready);
  modport sink   (input valid, input abs_sum, input sigma_q8, output ready);
endinterface

`default_nettype wire

/* src/lne_ctrl.sv */
// ----------------------------------------------------------------------------
// lne_ctrl
// Sequencer for pixel transfers, the frame-end multiply and the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lne_ctrl
  import lne_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        pix_valid,
  output logic             pix_ready,
  input  wire lne_status_t status,
  output lne_cmd_t         cmd
);

  localparam int STEP_W = $clog2(SIG_STEPS);

  lne_state_t        state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    pix_ready  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        pix_ready = 1'b1;
        if (pix_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        if (status.frame_end) begin
          cmd.finish = 1'b1;
          state_next = ST_MUL;
        end else begin
          pix_ready = 1'b1;
          if (pix_valid) begin
            cmd.take   = 1'b1;
            state_next = ST_CALC;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        step_next  = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + STEP_W'(1);
        if (step == STEP_W'(SIG_STEPS - 1)) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!status.out_full) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/lne_datapath.sv */
// ----------------------------------------------------------------------------
// lne_datapath
// Line buffers, 3x3 window, response sum, sigma divider and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lne_datapath
  import lne_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic [PIX_W-1:0]     pixel,
  input  wire lne_cmd_t             cmd,
  output lne_status_t               status,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [SUM_W-1:0]          abs_sum,
  output logic [SIG_W-1:0]          sigma_q8
);

  localparam int CNT_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int NW     = WW + HW;
  localparam int DIV_W  = ((NW + DIV_SHIFT) > PROD_W ? (NW + DIV_SHIFT) : PROD_W) + 1;
  localparam int RESP_W = PIX_W + 3;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  logic [WW-1:0] w;
  logic [HW-1:0] h;

  always_comb begin
    if (int'(image_width) < MIN_SIZE) begin
      w = WW'(MIN_SIZE);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(image_width);
    end
    if (int'(image_height) < MIN_SIZE) begin
      h = HW'(MIN_SIZE);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(image_height);
    end
  end

  logic [CNT_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             col_last;
  logic             row_last;
  logic [CNT_W-1:0] col_adv;
  logic [CNT_W-1:0] rd_addr;

  assign col_last = (WW'(col) + WW'(1)) >= w;
  assign row_last = (HW'(row) + HW'(1)) >= h;
  assign col_adv  = col_last ? '0 : col + CNT_W'(1);
  assign rd_addr  = cmd.calc ? col_adv : col;

  assign status.frame_end = col_last && row_last;
  assign status.out_full  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.calc) begin
      col <= col_adv;
      if (col_last) begin
        row <= row_last ? '0 : row + ROW_W'(1);
      end
    end
  end

  logic [PIX_W-1:0] line_top [MAX_WIDTH];
  logic [PIX_W-1:0] line_mid [MAX_WIDTH];
  logic [PIX_W-1:0] top_q;
  logic [PIX_W-1:0] mid_q;
  logic [PIX_W-1:0] pix;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      top_q <= line_top[rd_addr];
      mid_q <= line_mid[rd_addr];
      pix   <= pixel;
    end
    if (cmd.calc) begin
      line_top[col] <= mid_q;
      line_mid[col] <= pix;
    end
  end

  // Window columns: older column (a) and newer column (b), top/mid/bottom.
  logic [PIX_W-1:0] a_top, a_mid, a_bot;
  logic [PIX_W-1:0] b_top, b_mid, b_bot;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_top <= '0;
      a_mid <= '0;
      a_bot <= '0;
      b_top <= '0;
      b_mid <= '0;
      b_bot <= '0;
    end else if (cmd.calc) begin
      a_top <= b_top;
      a_mid <= b_mid;
      a_bot <= b_bot;
      b_top <= top_q;
      b_mid <= mid_q;
      b_bot <= pix;
    end
  end

  logic [RESP_W-1:0] pos_sum;
  logic [RESP_W-1:0] neg_sum;
  logic [RESP_W-1:0] diff;
  logic [PIX_W-1:0]  resp;
  logic              interior;
  logic [ACC_W:0]    acc_sum;
  logic [ACC_W-1:0]  acc_new;
  logic [ACC_W-1:0]  acc;

  always_comb begin
    pos_sum = RESP_W'(a_top) + RESP_W'(top_q) + RESP_W'(a_bot) + RESP_W'(pix)
            + (RESP_W'(b_mid) << 2);
    neg_sum = (RESP_W'(b_top) + RESP_W'(a_mid) + RESP_W'(mid_q) + RESP_W'(b_bot)) << 1;
    diff    = (pos_sum >= neg_sum) ? (pos_sum - neg_sum) : (neg_sum - pos_sum);
    resp    = (diff > RESP_W'({PIX_W{1'b1}})) ? {PIX_W{1'b1}} : diff[PIX_W-1:0];
    interior = (row >= ROW_W'(2)) && (col >= CNT_W'(2));
    acc_sum = {1'b0, acc} + (interior ? (ACC_W + 1)'(resp) : '0);
    acc_new = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
  end

  logic [ACC_W-1:0] acc_hold;
  logic [NW-1:0]    n_reg;
  logic [PROD_W-1:0] prod;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [QUO_W-1:0] quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.calc) begin
      acc <= cmd.finish ? '0 : acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      acc_hold <= acc_new;
      n_reg    <= NW'(w - WW'(2)) * NW'(h - HW'(2));
    end
    if (cmd.mul) begin
      prod <= PROD_W'(acc_hold) * PROD_W'(SIGMA_COEF);
    end
    if (cmd.prep) begin
      rem <= DIV_W'(prod) + (DIV_W'(n_reg) << ROUND_SHIFT);
      dvs <= DIV_W'(n_reg) << DIV_SHIFT;
      quo <= '0;
    end else if (cmd.div_step) begin
      if (rem >= dvs) begin
        rem <= rem - dvs;
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
      dvs <= dvs >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      abs_sum  <= acc_hold[ACC_W-1] ? {SUM_W{1'b1}} : acc_hold[SUM_W-1:0];
      sigma_q8 <= quo[QUO_W-1] ? {SIG_W{1'b1}} : quo[SIG_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* src/laplacian_noise_estimator_top.sv */
// A pixel is summed in the cycle after its transfer; the frame result is
// valid after the multiply, divider and result load following the last pixel.
// Throughput: one pixel per cycle within a frame, set by the registered line
// buffer read; at each frame end input stalls for the multiply and the
// 15-step restoring divider, longer while the previous result still waits.
// Reset clears control, counters, window, sum and result valid, sets 640x480.
// ----------------------------------------------------------------------------
// laplacian_noise_estimator_top
// Frame noise sigma estimate from a 3x3 Laplacian over an 8-bit luma stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "laplacian_noise_estimator_top_macros.svh"

module laplacian_noise_estimator_top
  import lne_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  lne_pixel_if.sink                 pixels,
  lne_result_if.source              results
);

  lne_cmd_t    cmd;
  lne_status_t status;

  lne_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pixels.valid),
    .pix_ready (pixels.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lne_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pixels.pixel),
    .cmd       (cmd),
    .status    (status),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .abs_sum   (results.abs_sum),
    .sigma_q8  (results.sigma_q8)
  );

  `LNE_ASSERT_NEXT(a_take_then_calc, clk, rst, cmd.take, cmd.calc)
  `LNE_ASSERT_NEXT(a_load_shows_result, clk, rst, cmd.load, results.valid)
  `LNE_ASSERT_IMPLY(a_no_result_overwrite, clk, rst, cmd.load, !(results.valid && !results.ready))
  `LNE_ASSERT_NEXT(a_stall_after_frame, clk, rst, cmd.finish, !pixels.ready)

endmodule

`default_nettype wire

/* test/tb_laplacian_noise_estimator_top.sv */
// ----------------------------------------------------------------------------
// Laplacian noise estimator testbench
// Streams frames of luma pixels through the estimator under random idling on
// both channels. A scoreboard tracks line buffers, the 3x3 window, the frame
// counters and the response sum, and checks every per-frame result field by
// field. The run covers the smallest frame size, wide and tall frames,
// out-of-range sizes, size changes within a frame and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import lne_pkg::*;

localparam int unsigned SIGMA_Q16 = 13689;
localparam longint unsigned SUM_LIMIT = 64'h1_FFFF_FFFF;
localparam int unsigned SIGMA_LIMIT = (1 << SIG_W) - 1;

typedef struct packed {
  logic [SUM_W-1:0] abs_sum;
  logic [SIG_W-1:0] sigma_q8;
} frame_stats_t;

class sigma_tracker;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [PIX_W-1:0] lines [2*DEF_MAX_WIDTH];
  logic [PIX_W-1:0] win [6];
  int unsigned col;
  int unsigned row;
  longint unsigned acc;
  frame_stats_t due [$];
  int unsigned frames_predicted;
  int unsigned errors;

  function void clear();
    width_reg = RESET_WIDTH;
    height_reg = RESET_HEIGHT;
    foreach (lines[i]) lines[i] = '0;
    foreach (win[i]) win[i] = '0;
    col = 0;
    row = 0;
    acc = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    case (idx)
      REG_IMAGE_WIDTH: width_reg = value;
      REG_IMAGE_HEIGHT: height_reg = value;
      default: ;
    endcase
  endfunction

  function int unsigned clamp_size(logic [CFG_W-1:0] value, int unsigned hi);
    if (value < MIN_SIZE) return MIN_SIZE;
    if (value > hi) return hi;
    return value;
  endfunction

  function void take_pixel(logic [PIX_W-1:0] bot);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    int resp;
    longint unsigned area;
    longint unsigned quot;
    frame_stats_t stats;
    w = clamp_size(width_reg, DEF_MAX_WIDTH);
    h = clamp_size(height_reg, DEF_MAX_HEIGHT);
    c = col % DEF_MAX_WIDTH;
    top = lines[DEF_MAX_WIDTH + c];
    mid = lines[c];
    if (row >= 2 && col >= 2) begin
      resp = int'(win[0]) + int'(win[2]) + int'(top) + int'(bot) + 4 * int'(win[4])
           - 2 * (int'(win[1]) + int'(win[3]) + int'(win[5]) + int'(mid));
      if (resp < 0) resp = -resp;
      if (resp > 255) resp = 255;
      acc = acc + resp;
      if (acc > SUM_LIMIT) acc = SUM_LIMIT;
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = bot;
    lines[DEF_MAX_WIDTH + c] = mid;
    lines[c] = bot;
    if (col + 1 < w) begin
      col++;
      return;
    end
    col = 0;
    if (row + 1 < h) begin
      row++;
      return;
    end
    row = 0;
    area = w - 2;
    area = area * (h - 2);
    quot = (acc * SIGMA_Q16 + 128 * area) / (256 * area);
    stats.abs_sum = (acc > 64'hFFFF_FFFF) ? '1 : SUM_W'(acc);
    stats.sigma_q8 = (quot > SIGMA_LIMIT) ? SIG_W'(SIGMA_LIMIT) : SIG_W'(quot);
    due.push_back(stats);
    frames_predicted++;
    acc = 0;
  endfunction

  function void check_result(logic [SUM_W-1:0] abs_sum, logic [SIG_W-1:0] sigma_q8);
    frame_stats_t want;
    if (due.size() == 0) begin
      $error("result transfer with no frame pending: abs_sum %0d sigma_q8 %0d",
             abs_sum, sigma_q8);
      errors++;
      return;
    end
    want = due.pop_front();
    if (abs_sum !== want.abs_sum) begin
      $error("abs_sum: expected %0d, got %0d", want.abs_sum, abs_sum);
      errors++;
    end
    if (sigma_q8 !== want.sigma_q8) begin
      $error("sigma_q8: expected %0d, got %0d", want.sigma_q8, sigma_q8);
      errors++;
    end
  endfunction
endclass

module tb_laplacian_noise_estimator_top;

  localparam int unsigned RANDOM_PIXELS = 1100;
  localparam int unsigned RANDOM_FRAMES = 20;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned WHOLE_FRAME = 32'hFFFF_FFFF;

  typedef enum { PIX_ZERO, PIX_FULL, PIX_CHECKER, PIX_UNIFORM, PIX_NOISY } pix_kind_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  lne_pixel_if pix_if ();
  lne_result_if res_if ();

  sigma_tracker tracker;
  bit tx_calm;
  bit rx_calm;
  bit hold_off_req;
  bit rx_holding;
  int unsigned pixels_sent;
  int unsigned quiet_cycles;

  laplacian_noise_estimator_top i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixels(pix_if),
    .results(res_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_size(int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 2) return $urandom_range(0, MIN_SIZE - 1);
    if (r == 2) return $urandom_range(hi + 1, 4 * hi);
    return $urandom_range(MIN_SIZE, hi);
  endfunction

  function automatic logic [PIX_W-1:0] pixel_for(pix_kind_t kind, int unsigned idx,
                                                 int unsigned amp);
    int v;
    case (kind)
      PIX_ZERO: return '0;
      PIX_FULL: return '1;
      PIX_CHECKER: return ((idx % 2) != 0) ? '1 : '0;
      PIX_NOISY: begin
        v = 128 + int'($urandom_range(0, 2 * amp)) - int'(amp);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return PIX_W'(v);
      end
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(logic [PIX_W-1:0] value);
    int unsigned gap;
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      pix_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_if.pixel = value;
    pix_if.valid = 1'b1;
    do @(posedge clk); while (!pix_if.ready);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Stops at the end of the current frame or after max_count pixels.
  task automatic stream_pixels(pix_kind_t kind, int unsigned max_count);
    int unsigned idx;
    int unsigned amp;
    idx = 0;
    amp = $urandom_range(1, 140);
    do begin
      send_pixel(pixel_for(kind, idx, amp));
      idx++;
    end while ((tracker.col != 0 || tracker.row != 0) && idx < max_count);
  endtask

  task automatic drain_results();
    pix_if.valid = 1'b0;
    while (tracker.due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_W'(value);
    @(posedge clk);
    tracker.set_reg(idx, CFG_W'(value));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    drain_results();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (pix_if.valid && pix_if.ready) tracker.take_pixel(pix_if.pixel);
      if (res_if.valid && res_if.ready) tracker.check_result(res_if.abs_sum, res_if.sigma_q8);
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  initial begin
    int unsigned hold;
    res_if.ready = 1'b0;
    rx_holding = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        res_if.ready = 1'b0;
        rx_holding = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        rx_holding = 1'b0;
      end
      hold = pick_gap(rx_calm);
      if (hold != 0) begin
        res_if.ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      res_if.ready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  initial begin
    pix_kind_t kind;
    int unsigned pixel_base;
    int unsigned frame_base;
    int unsigned r;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = '0;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    hold_off_req = 1'b0;
    pixels_sent = 0;
    tracker = new;
    tracker.clear();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Flat frames give no response, and a checkerboard saturates every response.
    set_size(MIN_SIZE, MIN_SIZE);
    stream_pixels(PIX_ZERO, WHOLE_FRAME);
    stream_pixels(PIX_FULL, WHOLE_FRAME);
    stream_pixels(PIX_CHECKER, WHOLE_FRAME);

    // A wide frame with an undersized height fills every column that later size
    // changes can reach, and a tall frame pairs with an undersized width.
    set_size(70, 2);
    stream_pixels(PIX_NOISY, WHOLE_FRAME);
    set_size(1, 60);
    stream_pixels(PIX_UNIFORM, WHOLE_FRAME);

    // Both sizes shrink in the middle of a frame, the height below the current row.
    set_size(12, 10);
    stream_pixels(PIX_UNIFORM, 12 * 4 + 5);
    drain_results();
    write_reg(REG_IMAGE_WIDTH, 6);
    write_reg(REG_IMAGE_HEIGHT, 4);
    stream_pixels(PIX_UNIFORM, WHOLE_FRAME);

    // The output is held off while small frames keep coming, so the block fills up.
    set_size(MIN_SIZE, MIN_SIZE);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    hold_off_req = 1'b1;
    while (!rx_holding) @(negedge clk);
    hold_off_req = 1'b0;
    repeat (6) stream_pixels(PIX_UNIFORM, WHOLE_FRAME);

    pixel_base = pixels_sent;
    frame_base = tracker.frames_predicted;
    while (pixels_sent - pixel_base < RANDOM_PIXELS ||
           tracker.frames_predicted - frame_base < RANDOM_FRAMES) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      set_size(pick_size(12), pick_size(8));
      repeat ($urandom_range(1, 3)) begin
        r = $urandom_range(0, 9);
        if (r < 5) kind = PIX_NOISY;
        else if (r < 9) kind = PIX_UNIFORM;
        else kind = pix_kind_t'($urandom_range(0, 2));
        if ($urandom_range(0, 5) == 0) begin
          stream_pixels(kind, $urandom_range(1, 40));
          drain_results();
          write_reg(($urandom_range(0, 1) != 0) ? REG_IMAGE_HEIGHT : REG_IMAGE_WIDTH,
                    pick_size(12));
        end
        stream_pixels(kind, WHOLE_FRAME);
      end
    end

    drain_results();
    if (tracker.errors == 0 && tracker.due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
